>>> design/integer_to_roman_encoder_core_assert.svh
// Assertion macros used by the integer to Roman encoder RTL.
`ifndef INTEGER_TO_ROMAN_ENCODER_CORE_ASSERT_SVH
`define INTEGER_TO_ROMAN_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define IRE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("integer_to_roman_encoder_core: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define IRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("integer_to_roman_encoder_core: next-cycle check failed");

`endif

>>> design/iroman_pkg.sv
`timescale 1ns / 1ps

package iroman_pkg;

    localparam int unsigned VALUE_W   = 12;
    localparam int unsigned LETTER_W  = 7;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned BCD_W     = 16;
    localparam int unsigned POS_W     = 2;
    localparam int unsigned LEN_W     = 3;
    localparam int unsigned REP_W     = 2;
    localparam int unsigned CNT_W     = 4;

    localparam logic [VALUE_W-1:0]  MAX_VALUE = 12'd3999;
    localparam logic [CNT_W-1:0]    CONV_LAST = CNT_W'(VALUE_W - 1);

    localparam logic [LETTER_W-1:0] CH_I    = 7'h49;
    localparam logic [LETTER_W-1:0] CH_V    = 7'h56;
    localparam logic [LETTER_W-1:0] CH_X    = 7'h58;
    localparam logic [LETTER_W-1:0] CH_L    = 7'h4C;
    localparam logic [LETTER_W-1:0] CH_C    = 7'h43;
    localparam logic [LETTER_W-1:0] CH_D    = 7'h44;
    localparam logic [LETTER_W-1:0] CH_M    = 7'h4D;
    localparam logic [LETTER_W-1:0] CH_NONE = 7'h00;

    function automatic logic [LETTER_W-1:0] unit_letter(input logic [POS_W-1:0] pos);
        logic [LETTER_W-1:0] ch;
        case (pos)
            2'd0:    ch = CH_I;
            2'd1:    ch = CH_X;
            2'd2:    ch = CH_C;
            default: ch = CH_M;
        endcase
        return ch;
    endfunction

    function automatic logic [LETTER_W-1:0] five_letter(input logic [POS_W-1:0] pos);
        logic [LETTER_W-1:0] ch;
        case (pos)
            2'd0:    ch = CH_V;
            2'd1:    ch = CH_L;
            2'd2:    ch = CH_D;
            default: ch = CH_NONE;
        endcase
        return ch;
    endfunction

    function automatic logic [LETTER_W-1:0] ten_letter(input logic [POS_W-1:0] pos);
        logic [LETTER_W-1:0] ch;
        case (pos)
            2'd0:    ch = CH_X;
            2'd1:    ch = CH_C;
            2'd2:    ch = CH_M;
            default: ch = CH_NONE;
        endcase
        return ch;
    endfunction

    // Number of letters one decimal digit produces.
    function automatic logic [LEN_W-1:0] digit_len(input logic [DIGIT_W-1:0] dig);
        logic [LEN_W-1:0] n;
        case (dig) inside
            4'd1, 4'd5:       n = 3'd1;
            4'd2, 4'd4, 4'd6: n = 3'd2;
            4'd9:             n = 3'd2;
            4'd3, 4'd7:       n = 3'd3;
            4'd8:             n = 3'd4;
            default:          n = 3'd0;
        endcase
        return n;
    endfunction

    // Letter number k of the digit at decimal position pos.
    function automatic logic [LETTER_W-1:0] digit_letter(input logic [DIGIT_W-1:0] dig,
                                                         input logic [REP_W-1:0]   k,
                                                         input logic [POS_W-1:0]   pos);
        logic [LETTER_W-1:0] ch;
        case (dig) inside
            [4'd1:4'd3]: ch = unit_letter(pos);
            4'd4:        ch = (k == '0) ? unit_letter(pos) : five_letter(pos);
            4'd5:        ch = five_letter(pos);
            [4'd6:4'd8]: ch = (k == '0) ? five_letter(pos) : unit_letter(pos);
            4'd9:        ch = (k == '0) ? unit_letter(pos) : ten_letter(pos);
            default:     ch = CH_NONE;
        endcase
        return ch;
    endfunction

endpackage

>>> design/integer_to_roman_encoder_core.sv
`timescale 1ns / 1ps
// Integer to Roman numeral encoder. Pulse start while busy is low to hand in
// i_value; each numeral letter then appears on o_letter for exactly one cycle
// with o_strobe high, thousands first, and o_last marks the final letter. The
// receiver cannot stall, so it must take every strobed word as it comes.
// A value of zero produces no word; a value above 3999 produces one word with
// o_error and o_last set and o_letter zero, through the S_ERR state. A valid
// value first runs through a bit-serial binary to BCD converter, one input bit
// per cycle, then the letter stage walks the four decimal digits, one letter
// per cycle, with a step that gives no letter for each zero digit ahead of the
// last letter. The value 3888 gives the longest numeral.
`include "integer_to_roman_encoder_core_assert.svh"

module integer_to_roman_encoder_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic [iroman_pkg::VALUE_W-1:0]    i_value,
    output logic                              busy,
    output logic                              o_strobe,
    output logic [iroman_pkg::LETTER_W-1:0]   o_letter,
    output logic                              o_last,
    output logic                              o_error
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT,
        S_ERR
    } t_state;

    t_state                            r_state,  n_state;
    logic [iroman_pkg::VALUE_W-1:0]    r_bin,    n_bin;
    logic [iroman_pkg::BCD_W-1:0]      r_bcd,    n_bcd;
    logic [iroman_pkg::CNT_W-1:0]      r_cnt,    n_cnt;
    logic [iroman_pkg::POS_W-1:0]      r_pos,    n_pos;
    logic [iroman_pkg::REP_W-1:0]      r_k,      n_k;
    logic                              r_strobe, n_strobe;
    logic [iroman_pkg::LETTER_W-1:0]   r_letter, n_letter;
    logic                              r_last,   n_last;
    logic                              r_error,  n_error;

    logic [iroman_pkg::BCD_W-1:0]      bcd_adj;
    logic [iroman_pkg::DIGIT_W-1:0]    cur_digit;
    logic [iroman_pkg::LEN_W-1:0]      cur_len;
    logic                              rest_zero;
    logic                              digit_done;

    // Add 3 to every BCD digit of 5 or more before the next shift.
    always_comb begin
        for (int i = 0; i < iroman_pkg::BCD_W / iroman_pkg::DIGIT_W; i++) begin
            if (r_bcd[i*iroman_pkg::DIGIT_W +: iroman_pkg::DIGIT_W] >= 4'd5) begin
                bcd_adj[i*iroman_pkg::DIGIT_W +: iroman_pkg::DIGIT_W] =
                    r_bcd[i*iroman_pkg::DIGIT_W +: iroman_pkg::DIGIT_W] + 4'd3;
            end else begin
                bcd_adj[i*iroman_pkg::DIGIT_W +: iroman_pkg::DIGIT_W] =
                    r_bcd[i*iroman_pkg::DIGIT_W +: iroman_pkg::DIGIT_W];
            end
        end
    end

    assign cur_digit  = r_bcd[iroman_pkg::BCD_W-1 -: iroman_pkg::DIGIT_W];
    assign cur_len    = iroman_pkg::digit_len(cur_digit);
    assign rest_zero  = (r_bcd[iroman_pkg::BCD_W-iroman_pkg::DIGIT_W-1:0] == '0);
    assign digit_done = ({1'b0, r_k} == cur_len - 3'd1);

    always_comb begin
        n_state  = r_state;
        n_bin    = r_bin;
        n_bcd    = r_bcd;
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_k      = r_k;
        n_strobe = 1'b0;
        n_letter = r_letter;
        n_last   = r_last;
        n_error  = r_error;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_value > iroman_pkg::MAX_VALUE) begin
                        n_state = S_ERR;
                    end else if (i_value != '0) begin
                        n_bin   = i_value;
                        n_bcd   = '0;
                        n_cnt   = '0;
                        n_state = S_CONV;
                    end
                end
            end
            S_CONV: begin
                // Shift one binary bit into the BCD word.
                n_bcd = {bcd_adj[iroman_pkg::BCD_W-2:0], r_bin[iroman_pkg::VALUE_W-1]};
                n_bin = {r_bin[iroman_pkg::VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == iroman_pkg::CONV_LAST) begin
                    n_pos   = '1;
                    n_k     = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (cur_len == '0) begin
                    // Zero digit: advance to the next position.
                    n_bcd = {r_bcd[iroman_pkg::BCD_W-iroman_pkg::DIGIT_W-1:0],
                             {iroman_pkg::DIGIT_W{1'b0}}};
                    n_pos = r_pos - 2'd1;
                    if (rest_zero) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_strobe = 1'b1;
                    n_letter = iroman_pkg::digit_letter(cur_digit, r_k, r_pos);
                    n_last   = digit_done && rest_zero;
                    n_error  = 1'b0;
                    if (digit_done) begin
                        n_bcd = {r_bcd[iroman_pkg::BCD_W-iroman_pkg::DIGIT_W-1:0],
                                 {iroman_pkg::DIGIT_W{1'b0}}};
                        n_pos = r_pos - 2'd1;
                        n_k   = '0;
                        if (rest_zero) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end
            end
            S_ERR: begin
                n_strobe = 1'b1;
                n_letter = iroman_pkg::CH_NONE;
                n_last   = 1'b1;
                n_error  = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_cnt    <= '0;
            r_pos    <= '0;
            r_k      <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_cnt    <= n_cnt;
            r_pos    <= n_pos;
            r_k      <= n_k;
        end
        r_bin    <= n_bin;
        r_bcd    <= n_bcd;
        r_letter <= n_letter;
        r_last   <= n_last;
        r_error  <= n_error;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_letter = r_letter;
    assign o_last   = r_last;
    assign o_error  = r_error;

    `IRE_ASSERT_SAME(a_err_word_form, i_clk, i_rst_n, o_strobe && o_error,
        o_last && (o_letter == iroman_pkg::CH_NONE))
    `IRE_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n,
        start && !busy && (i_value != '0), busy)
    `IRE_ASSERT_NEXT(a_gap_after_last, i_clk, i_rst_n, o_strobe && o_last, !o_strobe)
    `IRE_ASSERT_SAME(a_word_from_work, i_clk, i_rst_n, o_strobe, $past(busy))

endmodule

>>> tb/integer_to_roman_encoder_core_tb.sv
`timescale 1ns / 1ps

module integer_to_roman_encoder_core_tb;

    localparam int unsigned RANDOM_ITEMS = 206;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned TAIL_CYCLES  = 40;

    typedef logic [iroman_pkg::LETTER_W-1:0] t_letter;
    typedef logic [iroman_pkg::VALUE_W-1:0]  t_value;

    typedef struct packed {
        t_letter letter;
        logic    last;
        logic    error;
    } t_numeral_word;

    typedef struct {
        t_value value;
        logic   drain_first;
    } t_number_req;

    localparam t_letter ONE_CH  [4] = '{iroman_pkg::CH_I, iroman_pkg::CH_X,
                                        iroman_pkg::CH_C, iroman_pkg::CH_M};
    localparam t_letter FIVE_CH [4] = '{iroman_pkg::CH_V, iroman_pkg::CH_L,
                                        iroman_pkg::CH_D, iroman_pkg::CH_NONE};
    localparam t_letter TEN_CH  [4] = '{iroman_pkg::CH_X, iroman_pkg::CH_C,
                                        iroman_pkg::CH_M, iroman_pkg::CH_NONE};

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    t_value  i_value = '0;
    logic    busy;
    logic    o_strobe;
    t_letter o_letter;
    logic    o_last;
    logic    o_error;

    t_number_req   numbers_to_send[$];
    t_numeral_word numeral_words[$];
    int unsigned   words_due;
    int unsigned   numbers_taken;
    int unsigned   quiet_cycles;
    int unsigned   fail_count;

    integer_to_roman_encoder_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_value  (i_value),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_letter (o_letter),
        .o_last   (o_last),
        .o_error  (o_error)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void push_letter(input t_letter ch);
        t_numeral_word w;
        w.letter = ch;
        w.last   = 1'b0;
        w.error  = 1'b0;
        numeral_words.insert(numeral_words.size(), w);
    endfunction

    // Queue the letters of one number; return how many words it yields.
    function automatic int unsigned predict_numeral(input t_value v);
        int unsigned digit [4];
        int unsigned n;
        t_numeral_word w;
        n = numeral_words.size();
        if (v > iroman_pkg::MAX_VALUE) begin
            w.letter = iroman_pkg::CH_NONE;
            w.last   = 1'b1;
            w.error  = 1'b1;
            numeral_words.insert(numeral_words.size(), w);
            return 1;
        end
        digit[3] = v / 1000;
        digit[2] = (v / 100) % 10;
        digit[1] = (v / 10) % 10;
        digit[0] = v % 10;
        for (int p = 3; p >= 0; p--) begin
            if (digit[p] == 9) begin
                push_letter(ONE_CH[p]);
                push_letter(TEN_CH[p]);
            end else if (digit[p] == 4) begin
                push_letter(ONE_CH[p]);
                push_letter(FIVE_CH[p]);
            end else begin
                if (digit[p] >= 5)
                    push_letter(FIVE_CH[p]);
                for (int k = 0; k < digit[p] % 5; k++)
                    push_letter(ONE_CH[p]);
            end
        end
        if (numeral_words.size() > n)
            numeral_words[numeral_words.size() - 1].last = 1'b1;
        return numeral_words.size() - n;
    endfunction

    function automatic t_value random_number();
        int unsigned pick;
        int unsigned v;
        pick = $urandom_range(99);
        if (pick < 8)
            return '0;
        if (pick < 18)
            return t_value'(4000 + $urandom_range(95));
        if (pick < 42) begin
            // favor long digits (8, 9) to stretch the runs
            v = $urandom_range(3);
            for (int p = 0; p < 3; p++)
                v = v * 10 + ($urandom_range(1) ? $urandom_range(8, 9) : $urandom_range(9));
            return t_value'(v);
        end
        return t_value'($urandom_range(1, 3999));
    endfunction

    function automatic void add_number(input t_value v, input logic drain);
        t_number_req r;
        r.value       = v;
        r.drain_first = drain;
        numbers_to_send.insert(numbers_to_send.size(), r);
    endfunction

    // Driver: hold start while busy; otherwise feed the next number, with random gaps and a drain wait where asked.
    always @(posedge i_clk) begin
        int unsigned due;
        logic        go;
        if (!i_rst_n) begin
            start         <= 1'b0;
            i_value       <= '0;
            words_due     <= 0;
            numbers_taken <= 0;
        end else begin
            due = words_due;
            if (o_strobe && due != 0)
                due--;
            if (start && !busy) begin
                due += predict_numeral(i_value);
                void'(numbers_to_send.pop_front());
                numbers_taken <= numbers_taken + 1;
            end
            if (start && busy)
                go = 1'b1;
            else if (numbers_to_send.size() == 0)
                go = 1'b0;
            else if (numbers_to_send[0].drain_first && due != 0)
                go = 1'b0;
            else if (numbers_taken >= 90 && numbers_taken < 150)
                go = 1'b1;
            else
                go = ($urandom_range(99) >= 23);
            start <= go;
            if (go && !(start && busy))
                i_value <= numbers_to_send[0].value;
            else if (!go)
                i_value <= t_value'($urandom);
            words_due <= due;
        end
    end

    // Monitor: every strobed word must match the oldest predicted letter.
    always @(posedge i_clk) begin
        t_numeral_word want;
        if (i_rst_n && o_strobe) begin
            if (numeral_words.size() == 0) begin
                $error("unexpected word: letter %h last %b error %b",
                       o_letter, o_last, o_error);
                fail_count++;
            end else begin
                want = numeral_words.pop_front();
                if (o_letter !== want.letter) begin
                    $error("letter: expected %h, got %h", want.letter, o_letter);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, o_last);
                    fail_count++;
                end
                if (o_error !== want.error) begin
                    $error("error: expected %b, got %b", want.error, o_error);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        fail_count   = 0;
        quiet_cycles = 0;
        // extremes, each digit shape, over-range and zero
        add_number(12'd0, 1'b0);
        add_number(12'd1, 1'b0);
        add_number(12'd4, 1'b0);
        add_number(12'd5, 1'b0);
        add_number(12'd7, 1'b0);
        add_number(12'd9, 1'b0);
        add_number(12'd10, 1'b0);
        add_number(12'd40, 1'b0);
        add_number(12'd90, 1'b0);
        add_number(12'd400, 1'b0);
        add_number(12'd500, 1'b0);
        add_number(12'd900, 1'b0);
        add_number(12'd444, 1'b0);
        add_number(12'd999, 1'b0);
        add_number(12'd1000, 1'b0);
        add_number(12'd3000, 1'b0);
        add_number(12'd1994, 1'b0);
        add_number(12'd2048, 1'b0);
        add_number(12'd3888, 1'b0);
        add_number(12'd3999, 1'b0);
        add_number(12'd4000, 1'b0);
        add_number(12'd4095, 1'b0);
        add_number(12'd0, 1'b0);
        add_number(12'd1234, 1'b1);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            add_number(random_number(), (i % 60) == 59);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (numbers_to_send.size() != 0 || start)
            @(posedge i_clk);
        while (numeral_words.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> integer_to_roman_encoder_core.f
+incdir+design
design/iroman_pkg.sv
design/integer_to_roman_encoder_core.sv
tb/integer_to_roman_encoder_core_tb.sv
